// File: rtl/lru_key_value_cache_defines.svh
// Assertion macros for the LRU key-value cache RTL.
// Included by modules that carry concurrent checks; needs a clk and rst_n in scope.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every clock edge outside reset.
`define LKC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define LKC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define LKC_ASSERT_ALWAYS(lbl, expr, msg)
`define LKC_ASSERT_IMPL(lbl, ante, cons, msg)
`define LKC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/lkc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by lkc_cell and lru_key_value_cache.
package lkc_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request kinds on in_tuser
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic cmp;    // latch key compare result
    logic apply;  // commit the request to the row
    logic put;    // request is a put
    logic hit;    // key found somewhere in the row
    logic evict;  // put miss must drop the least recent entry
  } cell_ctl_t;

endpackage

// File: rtl/lkc_cell.sv
// One cache entry: valid, key, data, recency rank and latched compare.
// Depends on lkc_pkg; chained into a row by lru_key_value_cache.
module lkc_cell #(
  parameter int AGE_W = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lkc_pkg::cell_ctl_t        ctl_i,
  input  logic [lkc_pkg::KEY_W-1:0]  key_i,
  input  logic [lkc_pkg::DATA_W-1:0] wdata_i,
  input  logic [AGE_W-1:0]          old_age_i,   // rank of the hit entry
  input  logic [AGE_W-1:0]          last_age_i,  // rank of the least recent entry
  input  logic                      tok_i,       // no free slot taken upstream yet
  output logic                      tok_o,
  input  logic [lkc_pkg::DATA_W-1:0] rd_i,
  output logic [lkc_pkg::DATA_W-1:0] rd_o,
  input  logic [AGE_W-1:0]          age_i,
  output logic [AGE_W-1:0]          age_o,
  output logic                      valid_o,
  output logic                      match_o
);
  import lkc_pkg::*;

  logic              valid_r, valid_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [AGE_W-1:0]  age_r, age_nxt;
  logic              match_r, match_nxt;
  logic              my_evict, vacant, take;

  always_comb begin
    my_evict  = valid_r & ctl_i.evict & (age_r == last_age_i);
    vacant    = ~valid_r | my_evict;
    take      = vacant & tok_i;
    valid_nxt = valid_r;
    key_nxt   = key_r;
    data_nxt  = data_r;
    age_nxt   = age_r;
    match_nxt = match_r;
    if (ctl_i.cmp) begin
      match_nxt = valid_r & (key_r == key_i);
    end
    if (ctl_i.apply) begin
      if (ctl_i.hit) begin
        // move the hit entry to the front, shift newer ones back
        if (match_r) begin
          age_nxt = '0;
          if (ctl_i.put) begin
            data_nxt = wdata_i;
          end
        end else if (valid_r && (age_r < old_age_i)) begin
          age_nxt = age_r + AGE_W'(1);
        end
      end else if (ctl_i.put) begin
        if (take) begin
          valid_nxt = 1'b1;
          key_nxt   = key_i;
          data_nxt  = wdata_i;
          age_nxt   = '0;
        end else if (my_evict) begin
          valid_nxt = 1'b0;
          age_nxt   = '0;
        end else if (valid_r) begin
          age_nxt = age_r + AGE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    data_r <= data_nxt;
  end

  assign tok_o   = tok_i & ~vacant;
  assign rd_o    = rd_i | (match_r ? data_r : '0);
  assign age_o   = age_i | (match_r ? age_r : '0);
  assign valid_o = valid_r;
  assign match_o = match_r;

endmodule

// File: rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkc_pkg, lkc_cell and lru_key_value_cache_defines.svh.
//
// Usage:
//   in_*  : request channel. in_tuser is the kind (0 get, 1 put),
//           in_tdata holds key [31:0] and write value [63:32].
//   out_* : one response per request. out_tuser is hit, out_tdata the
//           read value (stored data on a get hit, zero otherwise).
//   cfg_* : capacity register (5 bits, reset 16). Zero acts as one,
//           values above ENTRIES act as ENTRIES. Write only while idle.
// Timing:
//   An accepted request first passes the compare state, which latches the key
//   compare in every cell, then the update state, which commits the update along
//   the cell row and loads the output register. The next request is taken in the
//   update state, while the current one commits; none is taken in the compare state.
// Reset:
//   The store comes up empty, capacity 16; no clearing pass is needed.
// Backpressure:
//   While out_tvalid is high and out_tready low, the update state waits with
//   in_tready low; nothing is dropped or repeated.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] key, [63:32] write_value
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_value
  output logic        out_tuser,  // [0] hit
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata   // [4:0] capacity
);
  import lkc_pkg::*;

  `include "lru_key_value_cache_defines.svh"

  localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // sequencer and request holding registers
  state_t            state_r, state_nxt;
  logic              req_put_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [DATA_W-1:0] req_wdata_r;
  logic              accept, out_free;

  // configuration and occupancy
  logic [CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_m1;
  logic [CMP_W-1:0]  cap_ext, eff_cap;
  logic              evict_need;

  // output register
  logic              out_tvalid_r;
  logic [DATA_W-1:0] out_tdata_r;
  logic              out_tuser_r;

  // cell row
  cell_ctl_t         ctl;
  logic              hit, slot_found;
  logic [AGE_W-1:0]  old_age, last_age;
  logic [ENTRIES-1:0] valid_vec, match_vec;
  logic              tok_c [0:ENTRIES];
  logic [DATA_W-1:0] rd_c  [0:ENTRIES];
  logic [AGE_W-1:0]  age_c [0:ENTRIES];

  assign out_free = ~out_tvalid_r | out_tready;
  assign accept   = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    ctl.cmp   = 1'b0;
    ctl.apply = 1'b0;
    ctl.put   = req_put_r;
    ctl.hit   = hit;
    ctl.evict = evict_need;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl.cmp   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          ctl.apply = 1'b1;
          in_tready = 1'b1;
          state_nxt = in_tvalid ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // effective capacity: zero acts as one, saturate at the row length
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    evict_need = CMP_W'(cnt_r) >= eff_cap;
    cnt_m1     = cnt_r - CNT_W'(1);
    last_age   = cnt_m1[AGE_W-1:0];
  end

  assign hit        = |match_vec;
  assign old_age    = age_c[ENTRIES];
  assign slot_found = ~tok_c[ENTRIES];

  assign tok_c[0] = 1'b1;
  assign rd_c[0]  = '0;
  assign age_c[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkc_cell #(
      .AGE_W (AGE_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl_i      (ctl),
      .key_i      (req_key_r),
      .wdata_i    (req_wdata_r),
      .old_age_i  (old_age),
      .last_age_i (last_age),
      .tok_i      (tok_c[i]),
      .tok_o      (tok_c[i+1]),
      .rd_i       (rd_c[i]),
      .rd_o       (rd_c[i+1]),
      .age_i      (age_c[i]),
      .age_o      (age_c[i+1]),
      .valid_o    (valid_vec[i]),
      .match_o    (match_vec[i])
    );
  end

  // occupancy: a put miss adds one, unless it displaced the oldest
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.apply && req_put_r && !hit && slot_found && !evict_need) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cap_r        <= CAP_RESET;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (ctl.apply) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_put_r   <= (in_tuser == KIND_PUT);
      req_key_r   <= in_tdata[KEY_W-1:0];
      req_wdata_r <= in_tdata[KEY_W+DATA_W-1:KEY_W];
    end
    if (ctl.apply) begin
      out_tuser_r <= hit;
      out_tdata_r <= (hit && !req_put_r) ? rd_c[ENTRIES] : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `LKC_ASSERT_ALWAYS(a_cnt_matches_valid, $countones(valid_vec) == int'(cnt_r),
    "occupancy count disagrees with valid cells")
  `LKC_ASSERT_ALWAYS(a_match_unique, $onehot0(match_vec),
    "key matched in more than one cell")
  `LKC_ASSERT_IMPL(a_put_miss_slot, ctl.apply && req_put_r && !hit, slot_found,
    "put miss found no free slot")
  `LKC_ASSERT_NEXT(a_apply_loads_out, ctl.apply, out_tvalid_r,
    "committed request did not load the output register")

endmodule

// File: tb/lru_key_value_cache_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LRU key-value cache: directed and random requests.
// Depends on lkc_pkg and the lru_key_value_cache RTL; holds its own LRU predictor.
module lru_key_value_cache_tb;
  import lkc_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int POOL_MAX    = 32;

  typedef struct {
    logic              hit;
    logic [DATA_W-1:0] value;
  } cache_response_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata   = '0;  // [31:0] key, [63:32] write_value
  logic              in_tuser   = KIND_GET;  // [0] kind
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;  // [31:0] read_value
  logic              out_tuser;  // [0] hit
  logic              cfg_we     = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata  = '0;  // [4:0] capacity

  // Shadow store of the cache
  logic              shadow_valid [ENTRIES];
  logic [KEY_W-1:0]  shadow_key   [ENTRIES];
  logic [DATA_W-1:0] shadow_data  [ENTRIES];
  int                shadow_rank  [ENTRIES];  // 0 = most recent
  int                shadow_count;
  logic [CAP_W-1:0]  shadow_capacity;

  cache_response_t   pending_responses[$];
  logic [KEY_W-1:0]  key_pool[POOL_MAX];

  int cycle_count  = 0;
  int fail_count   = 0;
  int request_count = 0;
  int checked_count = 0;
  int hit_count    = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_off     = 0;

  lru_key_value_cache #(.ENTRIES(ENTRIES)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_responses.size());
      $display("** lru_key_value_cache: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int effective_capacity();
    if (shadow_capacity == 0) return 1;
    if (shadow_capacity > ENTRIES) return ENTRIES;
    return int'(shadow_capacity);
  endfunction

  // Promote one entry to most recent; entries newer than it age by one.
  function automatic void promote_entry(int idx);
    int old_rank;
    old_rank = shadow_rank[idx];
    for (int j = 0; j < ENTRIES; j++)
      if (shadow_valid[j] && shadow_rank[j] < old_rank) shadow_rank[j]++;
    shadow_rank[idx] = 0;
  endfunction

  function automatic void insert_entry(logic [KEY_W-1:0] key, logic [DATA_W-1:0] value);
    int victim;
    int slot;
    victim = -1;
    slot   = -1;
    // Only one entry leaves, even when the count sits above a lowered capacity
    if (shadow_count >= effective_capacity()) begin
      for (int j = 0; j < ENTRIES; j++)
        if (shadow_valid[j] && (victim < 0 || shadow_rank[j] > shadow_rank[victim]))
          victim = j;
      if (victim >= 0) begin
        shadow_valid[victim] = 1'b0;
        shadow_rank[victim]  = 0;
        if (shadow_count > 0) shadow_count--;
      end
    end
    for (int j = 0; j < ENTRIES; j++)
      if (!shadow_valid[j] && slot < 0) slot = j;
    if (slot < 0) return;
    for (int j = 0; j < ENTRIES; j++)
      if (shadow_valid[j]) shadow_rank[j]++;
    shadow_valid[slot] = 1'b1;
    shadow_key[slot]   = key;
    shadow_data[slot]  = value;
    shadow_rank[slot]  = 0;
    shadow_count++;
  endfunction

  function automatic cache_response_t lru_access(logic kind, logic [KEY_W-1:0] key,
                                                 logic [DATA_W-1:0] value);
    cache_response_t rsp;
    int found;
    found = -1;
    for (int j = 0; j < ENTRIES; j++)
      if (found < 0 && shadow_valid[j] && shadow_key[j] == key) found = j;
    rsp.hit   = (found >= 0);
    rsp.value = '0;
    if (kind == KIND_GET) begin
      if (found >= 0) begin
        rsp.value = shadow_data[found];
        promote_entry(found);
      end
    end else if (found >= 0) begin
      shadow_data[found] = value;
      promote_entry(found);
    end else begin
      insert_entry(key, value);
    end
    return rsp;
  endfunction

  // ---------------------------------------------------------------- response side

  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off   <= hold_off - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : response_check
    cache_response_t exp_rsp;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_responses.size() == 0) begin
        $error("unexpected response: hit %0d read_value %h", out_tuser, out_tdata);
        fail_count++;
      end else begin
        exp_rsp = pending_responses.pop_front();
        checked_count++;
        if (exp_rsp.hit) hit_count++;
        if (out_tuser !== exp_rsp.hit) begin
          $error("hit: expected %0d, got %0d", exp_rsp.hit, out_tuser);
          fail_count++;
        end
        if (out_tdata !== exp_rsp.value) begin
          $error("read_value: expected %h, got %h", exp_rsp.value, out_tdata);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- request side

  // Valid stays high after acceptance; the next call or wait_drain moves it.
  task automatic send_request(logic kind, logic [KEY_W-1:0] key, logic [DATA_W-1:0] value);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {value, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_responses.push_back(lru_access(kind, key, value));
    request_count++;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called with the cache idle
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_capacity = cap;
  endtask

  task automatic set_idling(int tx_pct, int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct <= rx_pct;
  endtask

  // Extreme keys first, the rest random
  task automatic load_key_pool();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int j = 4; j < POOL_MAX; j++) key_pool[j] = $urandom;
  endtask

  // Mostly keys from a small pool so hits and evictions are frequent
  task automatic random_burst(int n, int pool_n);
    logic [KEY_W-1:0] key;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 88) key = key_pool[$urandom_range(pool_n - 1)];
      else key = $urandom;
      send_request(logic'($urandom_range(1)), key, $urandom);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_get_put_extremes();
    set_idling(0, 0);
    send_request(KIND_GET, 32'h0000_0000, 32'h1234_5678);  // get on empty store
    send_request(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(KIND_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(KIND_PUT, 32'h8000_0000, 32'hFFFF_FFFF);  // update in place
    send_request(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(KIND_GET, 32'h8000_0000, 32'h0000_0000);
    wait_drain();
  endtask

  task automatic test_single_entry();
    set_capacity(5'd1);
    send_request(KIND_PUT, 32'h0000_0001, 32'hAAAA_5555);
    send_request(KIND_PUT, 32'h0000_0002, 32'h5555_AAAA);  // drops key 1
    send_request(KIND_GET, 32'h0000_0001, 32'h0000_0000);
    send_request(KIND_GET, 32'h0000_0002, 32'h0000_0000);
    wait_drain();
    // capacity zero acts as one
    set_capacity(5'd0);
    send_request(KIND_PUT, 32'h0000_0003, 32'h0F0F_F0F0);
    send_request(KIND_GET, 32'h0000_0002, 32'h0000_0000);
    send_request(KIND_GET, 32'h0000_0003, 32'h0000_0000);
    wait_drain();
  endtask

  task automatic test_lru_order();
    set_capacity(5'd2);
    send_request(KIND_PUT, 32'hDEAD_0001, 32'h0000_0011);
    send_request(KIND_PUT, 32'hDEAD_0002, 32'h0000_0022);
    send_request(KIND_GET, 32'hDEAD_0001, 32'h0000_0000);  // key 1 now newest
    send_request(KIND_PUT, 32'hDEAD_0003, 32'h0000_0033);  // drops key 2
    send_request(KIND_GET, 32'hDEAD_0002, 32'h0000_0000);
    send_request(KIND_GET, 32'hDEAD_0001, 32'h0000_0000);
    wait_drain();
  endtask

  // Output held off while requests keep coming: the input must stall
  task automatic test_backpressure_fill();
    set_capacity(5'd16);
    set_idling(0, 20);
    load_key_pool();
    hold_off <= 80;
    random_burst(40, 20);
    wait_drain();
  endtask

  // Fill all entries, then drop the capacity below the count
  task automatic test_capacity_shrink();
    set_capacity(5'd16);
    set_idling(0, 0);
    load_key_pool();
    for (int i = 0; i < ENTRIES; i++) send_request(KIND_PUT, key_pool[i], $urandom);
    wait_drain();
    set_capacity(5'd3);
    set_idling(62, 0);
    random_burst(60, 20);
    wait_drain();
  endtask

  task automatic test_random_traffic(logic [CAP_W-1:0] cap, int tx_pct, int rx_pct,
                                     int pool_n, int n);
    set_capacity(cap);
    set_idling(tx_pct, rx_pct);
    load_key_pool();
    random_burst(n, pool_n);
    wait_drain();
  endtask

  initial begin
    for (int j = 0; j < ENTRIES; j++) begin
      shadow_valid[j] = 1'b0;
      shadow_key[j]   = '0;
      shadow_data[j]  = '0;
      shadow_rank[j]  = 0;
    end
    shadow_count    = 0;
    shadow_capacity = CAP_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_get_put_extremes();
    test_single_entry();
    test_lru_order();
    test_backpressure_fill();
    test_capacity_shrink();
    test_random_traffic(5'd16, 0,  0,  24, 120);
    test_random_traffic(5'd31, 62, 0,  24, 120);
    test_random_traffic(5'd4,  0,  62, 8,  120);
    test_random_traffic(5'd1,  36, 36, 3,  120);
    test_random_traffic(5'd17, 36, 36, 28, 120);
    test_random_traffic(5'd8,  62, 62, 12, 120);

    in_tvalid <= 1'b0;
    repeat (10) @(posedge clk);
    $display("Checked %0d responses for %0d requests (%0d hits), gets and puts over",
             checked_count, request_count, hit_count);
    $display("capacities 0..31 incl. shrink below count, stalls on both sides.");
    if (fail_count == 0 && pending_responses.size() == 0)
      $display("** lru_key_value_cache: PASSED **");
    else
      $display("** lru_key_value_cache: FAILED **");
    $finish;
  end

endmodule
